// ----- rtl/frm_pkg.sv -----
// Shared types and constants of the frame rate meter.
package frm_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned TPS_W    = 16;
  localparam int unsigned RATE_W   = 28;
  localparam int unsigned FRAMES_W = 4;
  localparam int unsigned FRAC_W   = 8;

  localparam logic [TPS_W-1:0]  TPS_RESET = 16'd1000;
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  typedef enum logic {
    OP_INIT  = 1'b0,
    OP_FRAME = 1'b1
  } frm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } frm_state_e;

  typedef struct packed {
    frm_op_e         op;
    logic [TS_W-1:0] delta;
  } frm_cmd_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [FRAMES_W-1:0] frames;
    logic                zero;
  } frm_res_t;

endpackage

// ----- rtl/frame_rate_meter.sv -----
// Flow: an init word goes from the queue straight to the result register; a frame
// word passes the ring update, the multiply and the one-bit-per-cycle rate divider.
// The back end takes no new word until the last one's result is registered, which
// waits while the result slot is full; a two-word queue buffers the input side.
// Reset: asynchronous, active low; clears the window, sum, fill count, queue
// and result flag, and loads a tick rate of 1000.
module frame_rate_meter #(
  parameter int unsigned WINDOW    = 10,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode_i,
  input  logic [31:0]                   timestamp_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [frm_pkg::RATE_W-1:0]    rate_q8_o,
  output logic [frm_pkg::FRAMES_W-1:0]  frames_in_window_o,
  output logic                          zero_time_o,
  input  logic                          ticks_per_second_we_i,
  input  logic [frm_pkg::TPS_W-1:0]     ticks_per_second_i
);
  import frm_pkg::*;

  logic [TPS_W-1:0] tps_q;
  logic             cmd_push;
  frm_cmd_t         cmd_in;
  frm_cmd_t         cmd_out;
  logic             cmd_valid;
  logic             cmd_pop;
  logic             res_valid;
  frm_res_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (ticks_per_second_we_i) begin
      tps_q <= ticks_per_second_i;
    end
  end

  frm_front #(
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .opcode_i    (opcode_i),
    .timestamp_i (timestamp_i),
    .q_full_i    (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  frm_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_in),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (full),
    .valid_o (cmd_valid)
  );

  frm_back #(
    .WINDOW    (WINDOW),
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .tps_i       (tps_q),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty              = !res_valid;
  assign rate_q8_o          = res.rate;
  assign frames_in_window_o = res.frames;
  assign zero_time_o        = res.zero;

  a_zero_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && zero_time_o) |-> (rate_q8_o == RATE_MAX))
    else $error("zero window time without saturated rate");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WINDOW < 16 && !empty && frames_in_window_o == '0) |->
      (rate_q8_o == '0 && !zero_time_o))
    else $error("empty window gave a nonzero rate");

  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("queue filled without an accepted word");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

endmodule

// ----- rtl/frm_front.sv -----
// Front end: accept timestamps, form wrapped tick deltas and queue commands.
module frm_front #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   opcode_i,
  input  logic [31:0]            timestamp_i,
  input  logic                   q_full_i,
  output logic                   cmd_push_o,
  output frm_pkg::frm_cmd_t      cmd_o
);
  import frm_pkg::*;

  localparam logic [TS_W-1:0] TickMask = TS_W'((64'd1 << TICK_BITS) - 64'd1);

  logic [TS_W-1:0] last_q, last_d;
  logic [TS_W-1:0] ts_m;
  logic            accept;

  assign accept = push_i && !q_full_i;
  assign ts_m   = timestamp_i & TickMask;
  assign last_d = accept ? ts_m : last_q;

  assign cmd_push_o = accept;
  assign cmd_o.op    = frm_op_e'(opcode_i);
  assign cmd_o.delta = (ts_m - last_q) & TickMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

// ----- rtl/frm_cmd_queue.sv -----
// Two-word command queue between the front end and the back end.
module frm_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  frm_pkg::frm_cmd_t wdata_i,
  input  logic              rd_i,
  output frm_pkg::frm_cmd_t rdata_o,
  output logic              full_o,
  output logic              valid_o
);
  import frm_pkg::*;

  frm_cmd_t    slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = slot_q[rd_ptr_q];

  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/frm_back.sv -----
// Back end: frame time ring, running sum, bit-serial rate divider, result word.
module frm_back #(
  parameter int unsigned WINDOW    = 10,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  frm_pkg::frm_cmd_t              cmd_i,
  output logic                           cmd_pop_o,
  input  logic [frm_pkg::TPS_W-1:0]      tps_i,
  input  logic                           res_pop_i,
  output logic                           res_valid_o,
  output frm_pkg::frm_res_t              res_o
);
  import frm_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = TICK_BITS + FILL_W;
  localparam int unsigned NUM_W  = TPS_W + FILL_W + FRAC_W;
  localparam int unsigned CNT_W  = $clog2(NUM_W);

  frm_state_e state_q, state_d;

  logic [TICK_BITS-1:0] ring_q [WINDOW];
  logic [TICK_BITS-1:0] ring_rd_q;
  logic                 ring_we;
  logic [WINDOW-1:0]    valid_q, valid_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [TICK_BITS-1:0] delta_q, delta_d;
  logic [NUM_W-1:0]     acc_q, acc_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  frm_res_t             pend_q, pend_d;
  frm_res_t             res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic [TICK_BITS-1:0] old_entry;
  logic [SUM_W:0]       rem_sh;
  logic                 rem_ge;
  logic [NUM_W-1:0]     quo;
  logic                 slot_free;

  assign old_entry = valid_q[ptr_q] ? ring_rd_q : '0;
  assign rem_sh    = {rem_q, acc_q[NUM_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, sum_q});
  assign quo       = {acc_q[NUM_W-2:0], rem_ge};
  assign slot_free = !res_valid_q || res_pop_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_FRAME) ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: state_d = ST_MUL;
      ST_MUL:    state_d = (sum_q == '0) ? ST_DONE : ST_DIV;
      ST_DIV:    state_d = (cnt_q == '0) ? ST_DONE : ST_DIV;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    ring_we     = 1'b0;
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    delta_d     = delta_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (res_pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          delta_d   = cmd_i.delta[TICK_BITS-1:0];
          if (cmd_i.op == OP_INIT) begin
            valid_d = '0;
            ptr_d   = '0;
            fill_d  = '0;
            sum_d   = '0;
            pend_d  = '0;
          end
        end
      end
      ST_UPDATE: begin
        ring_we        = 1'b1;
        valid_d[ptr_q] = 1'b1;
        sum_d          = sum_q - SUM_W'(old_entry) + SUM_W'(delta_q);
        ptr_d          = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
        fill_d         = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + FILL_W'(1);
      end
      ST_MUL: begin
        acc_d       = (NUM_W'(tps_i) * NUM_W'(fill_q)) << FRAC_W;
        rem_d       = '0;
        cnt_d       = CNT_W'(NUM_W - 1);
        pend_d.rate   = RATE_MAX;
        pend_d.frames = FRAMES_W'(fill_q);
        pend_d.zero   = (sum_q == '0);
      end
      ST_DIV: begin
        acc_d = quo;
        rem_d = rem_ge ? SUM_W'(rem_sh - {1'b0, sum_q}) : SUM_W'(rem_sh);
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          pend_d.rate = ((quo >> RATE_W) != '0) ? RATE_MAX : RATE_W'(quo);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    pend_q  <= pend_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ptr_q] <= delta_q;
    end
    ring_rd_q <= ring_q[ptr_q];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
